@@ rtl/core/msat_pkg.sv @@
// msat_pkg: shared types, constants and the unit scale table for the
// multichannel averaging sensor table; depends on nothing else
`default_nettype none

package msat_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int SAMPLE_W     = 32;
    localparam int LEN_W        = 5;
    localparam int UNIT_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int SCALE_W      = 21;   // largest factor is 1.0 in Q1.20
    localparam int SUM_W        = 36;   // 31 * (2^31 - 1) + 2^31 fits
    localparam int CNT_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    // command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_VALUE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

    // unit codes
    localparam logic [UNIT_W-1:0] UNIT_BASE   = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_CENTI  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_TORR   = 2'd2;

    typedef struct packed {
        logic                       cmd;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic [UNIT_W-1:0]          unit;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [STATUS_W-1:0] status;
    } t_out;

    // rounded q1.20 unit factors; the spare code behaves as the base unit
    function automatic logic [SCALE_W-1:0] unit_scale(input logic [UNIT_W-1:0] unit);
        logic [SCALE_W-1:0] scale;
        unique case (unit)
            UNIT_CENTI: scale = 21'd10486;
            UNIT_TORR:  scale = 21'd7865;
            default:    scale = 21'd1048576;
        endcase
        return scale;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/multichannel_averaging_sensor_table_top.sv @@
// multichannel averaging sensor table: per-channel moving average filter
// with bit-serial multiply and divide; depends on msat_pkg
// update with averaging: 5 multiply steps, 1 add, 36 divide steps; no new request is taken until it ends
// read of a valid channel: 21 multiply steps, then the result waits in S_WAIT for the output register
// read with a bad status: no multiply steps, straight to S_WAIT; other updates are done at acceptance
// synchronous active-low reset: all channels invalid, in-use 0, enable 0, length 3
`default_nettype none

module multichannel_averaging_sensor_table_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request channel
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  msat_pkg::t_in                     i_in,
    // result channel
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output msat_pkg::t_out                    o_out,
    // register write channel
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [msat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [msat_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import msat_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a request
    localparam logic [2:0] S_MUL  = 3'd1;   // (k-1) * old, one bit of k-1 a cycle
    localparam logic [2:0] S_ADD  = 3'd2;   // add the new sample
    localparam logic [2:0] S_DIV  = 3'd3;   // restoring divide, one quotient bit a cycle
    localparam logic [2:0] S_RMUL = 3'd4;   // value * unit factor, one factor bit a cycle
    localparam logic [2:0] S_WAIT = 3'd5;   // hand the read result to the output register

    // configuration registers
    logic [3:0]              r_cfg_in_use;
    logic [NUM_CHANNELS-1:0] r_cfg_enable;
    logic [LEN_W-1:0]        r_cfg_len;

    // channel store: values are only looked at while their valid bit is set
    logic [SAMPLE_W-1:0]     r_fv [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;

    // sequencer and datapath
    logic [2:0]              r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [CH_W-1:0]         r_ch;
    logic [SAMPLE_W-1:0]     r_sample;
    logic [SAMPLE_W-1:0]     r_mcand;   // stored value of the addressed channel
    logic [SUM_W-1:0]        r_acc;     // weighted sum, then quotient shift register
    logic [LEN_W-1:0]        r_rem;     // divide remainder, always below k
    logic [SAMPLE_W-1:0]     r_phi;     // upper product half
    logic [SCALE_W-1:0]      r_mlo;     // factor bits, replaced by low product bits
    logic [STATUS_W-1:0]     r_status;

    // output register
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    in_fire;
    logic                    present;
    logic                    enabled;
    logic                    positive;
    logic [LEN_W-1:0]        km1;
    logic [LEN_W:0]          div_try;
    logic                    div_ge;
    logic [LEN_W:0]          div_rem;
    logic [SUM_W-1:0]        div_shift;
    logic [SAMPLE_W:0]       mul_sum;
    logic                    out_load;
    logic                    wr_en;
    logic [SAMPLE_W-1:0]     wr_data;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;

    // channel must lie below the in-use count and the table depth
    assign present  = ({1'b0, i_in.channel} < r_cfg_in_use) &&
                      (int'(i_in.channel) < NUM_CHANNELS);
    assign enabled  = r_cfg_enable[i_in.channel];
    assign positive = !i_in.sample[SAMPLE_W-1] && (|i_in.sample);
    assign km1      = r_cfg_len - LEN_W'(1);

    // one restoring divide step: bring down the next sum bit
    assign div_try   = {r_rem, r_acc[SUM_W-1]};
    assign div_ge    = (div_try >= {1'b0, r_cfg_len});
    assign div_rem   = div_ge ? (div_try - {1'b0, r_cfg_len}) : div_try;
    assign div_shift = {r_acc[SUM_W-2:0], div_ge};

    // one shift-add step of the unit scaling, lsb of the factor first
    assign mul_sum = {1'b0, r_phi} + (r_mlo[0] ? {1'b0, r_mcand} : '0);

    // a finished read moves on once the output register is free or being drained
    assign out_load = (r_state == S_WAIT) && (!r_out_valid || i_out_ready);

    // store writes: direct loads at acceptance, quotient at the last divide step
    always_comb begin
        wr_en   = 1'b0;
        wr_data = i_in.sample;
        if (in_fire && i_in.cmd == CMD_UPDATE && present && enabled && positive &&
            (!r_valid[i_in.channel] || r_cfg_len <= LEN_W'(1))) begin
            wr_en = 1'b1;
        end else if (r_state == S_DIV && r_cnt == '0) begin
            wr_en   = 1'b1;
            wr_data = div_shift[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fv[(r_state == S_IDLE) ? i_in.channel : r_ch] <= wr_data;
        end
    end

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_in_use <= '0;
            r_cfg_enable <= '0;
            r_cfg_len    <= LEN_W'(3);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IN_USE: r_cfg_in_use <= i_cfg_data[3:0];
                CFG_ENABLE: r_cfg_enable <= i_cfg_data[NUM_CHANNELS-1:0];
                CFG_LENGTH: r_cfg_len    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in.cmd == CMD_READ) begin
                            // good reads scale, others report straight away
                            if (present && r_valid[i_in.channel]) begin
                                r_state <= S_RMUL;
                            end else begin
                                r_state <= S_WAIT;
                            end
                        end else if (present && enabled) begin
                            if (!positive) begin
                                r_valid[i_in.channel] <= 1'b0;
                            end else if (!r_valid[i_in.channel] ||
                                         r_cfg_len <= LEN_W'(1)) begin
                                r_valid[i_in.channel] <= 1'b1;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RMUL: begin
                    if (r_cnt == '0) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ch     <= i_in.channel;
                r_sample <= i_in.sample;
                r_mcand  <= r_fv[i_in.channel];
                r_acc    <= '0;
                r_rem    <= '0;
                r_phi    <= '0;
                if (i_in.cmd == CMD_READ) begin
                    r_cnt <= CNT_W'(SCALE_W - 1);
                end else begin
                    r_cnt <= CNT_W'(LEN_W - 1);
                end
                // a failed read keeps a zero product so the value reads zero
                if (!present) begin
                    r_status <= ST_ABSENT;
                    r_mlo    <= '0;
                end else if (!r_valid[i_in.channel]) begin
                    r_status <= ST_NO_VALUE;
                    r_mlo    <= '0;
                end else begin
                    r_status <= ST_OK;
                    r_mlo    <= unit_scale(i_in.unit);
                end
            end
            S_MUL: begin
                // msb of k-1 first
                r_acc <= {r_acc[SUM_W-2:0], 1'b0} +
                         (km1[r_cnt[2:0]] ? {{(SUM_W-SAMPLE_W){1'b0}}, r_mcand} : '0);
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_ADD: begin
                r_acc <= r_acc + {{(SUM_W-SAMPLE_W){1'b0}}, r_sample};
                r_cnt <= CNT_W'(SUM_W - 1);
            end
            S_DIV: begin
                r_acc <= div_shift;
                r_rem <= div_rem[LEN_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_RMUL: begin
                r_phi <= mul_sum[SAMPLE_W:1];
                r_mlo <= {mul_sum[0], r_mlo[SCALE_W-1:1]};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_WAIT: ;
            default: ;
        endcase
    end

    // output register: full product is {r_phi, r_mlo}, value is it shifted by 20
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.value  <= {r_phi[SAMPLE_W-2:0], r_mlo[SCALE_W-1]};
            r_out.status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // remainder stays below the divisor throughout the divide
    a_rem_below_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_cfg_len))
        else $error("divide remainder not below filter length");

    // a result with a bad status carries a zero value
    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> (o_out.value == '0))
        else $error("non-ok result with non-zero value");

    // an accepted update never makes a result appear
    a_update_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.cmd == CMD_UPDATE) |=> !(r_state == S_WAIT))
        else $error("update reached the result stage");

    // a finished read lands in the output register
    a_wait_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("read result not loaded");

endmodule

`default_nettype wire
